FILE: hw/rtl/dedup_message_store_table_core_assert.svh
// Assertion helpers for the message table core.
`ifndef DEDUP_MESSAGE_STORE_TABLE_CORE_ASSERT_SVH
`define DEDUP_MESSAGE_STORE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DMST_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmst check failed");

// Next-cycle implication, checked out of reset.
`define DMST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmst check failed");

`endif

FILE: hw/rtl/dmst_pkg.sv
`timescale 1ns / 1ps

package dmst_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_MARK  = 2'd1;
    localparam logic [1:0] MODE_PEEK  = 2'd2;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_MARKED    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_PEEK      = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] msg_id;
        logic        msg_delivered;
        logic [63:0] msg_payload;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        accepted;
        logic        pending_valid;
        logic [31:0] pending_id;
        logic [63:0] pending_payload;
        logic [4:0]  pending_count;
        logic [4:0]  stored_count;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic read;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic fill_zero;
        logic rd_last;
    } t_sts;

endpackage

FILE: hw/rtl/dedup_message_store_table_core.sv
`timescale 1ns / 1ps
// channel   | ports                        | direction
// ----------+------------------------------+----------
// command   | start, busy, i_item          | in, busy out
// result    | o_res_vld, o_res             | out
//
// Once a beat is accepted, busy stays high while the controller does one registered
// table read per entry held at its start, then a drain state and a commit state; an
// empty table goes straight to commit. The result strobe follows in the cycle after
// commit, with busy already low.
// Synchronous active-low reset empties the table; entry contents are not cleared.
// The result strobe lasts one cycle and cannot be stalled; busy holds off start.

module dedup_message_store_table_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dmst_pkg::t_in  i_item,
    output dmst_pkg::t_out o_res,
    output logic           o_res_vld
);
    import dmst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    dmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    dmst_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_item    (i_item),
        .o_sts     (w_sts),
        .o_res     (o_res),
        .o_res_vld (o_res_vld)
    );

`include "dedup_message_store_table_core_assert.svh"

    `DMST_NEXT(a_accept_busy, start && !busy, busy)
    `DMST_IMPLIES(a_res_idle, o_res_vld, !busy)
    `DMST_NEXT(a_res_single, o_res_vld, !o_res_vld)
    `DMST_IMPLIES(a_no_pend_zero, o_res_vld && !o_res.pending_valid,
        (o_res.pending_id == '0) && (o_res.pending_payload == '0))

endmodule

FILE: hw/rtl/dmst_ctrl.sv
`timescale 1ns / 1ps

module dmst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  dmst_pkg::t_sts i_sts,
    output dmst_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import dmst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_sts.fill_zero ? S_COMMIT : S_READ;
                end
            end
            S_READ: begin
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.read   = (r_state == S_READ);
        o_cmd.commit = (r_state == S_COMMIT);
        o_busy       = (r_state != S_IDLE);
    end

endmodule

FILE: hw/rtl/dmst_dpath.sv
`timescale 1ns / 1ps

module dmst_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dmst_pkg::t_cmd i_cmd,
    input  dmst_pkg::t_in  i_item,
    output dmst_pkg::t_sts o_sts,
    output dmst_pkg::t_out o_res,
    output logic           o_res_vld
);
    import dmst_pkg::*;

    logic [31:0]             mem_id   [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0] mem_pay  [MAX_ENTRIES];
    logic                    mem_done [MAX_ENTRIES];

    t_in                     r_in;
    logic [CNT_W-1:0]        r_fill;
    logic [IDX_W-1:0]        r_rd_idx;
    logic [IDX_W-1:0]        r_ev_idx;
    logic                    r_dv;
    logic [31:0]             r_q_id;
    logic [PAYLOAD_BITS-1:0] r_q_pay;
    logic                    r_q_done;

    logic                    r_found;
    logic [IDX_W-1:0]        r_m_idx;
    logic                    r_pv;
    logic [31:0]             r_pid;
    logic [PAYLOAD_BITS-1:0] r_ppay;
    logic [CNT_W-1:0]        r_pend;

    t_out                    r_res;
    logic                    r_res_vld;

    logic                    is_store;
    logic                    is_mark;
    logic                    full;
    logic                    match_now;
    logic                    eff_done;
    logic                    do_append;
    logic                    do_mark;
    logic [IDX_W-1:0]        wr_idx;

    logic                    n_pv;
    logic [31:0]             n_pid;
    logic [PAYLOAD_BITS-1:0] n_ppay;
    logic [CNT_W-1:0]        n_pend;
    logic [CNT_W-1:0]        n_fill;
    logic [2:0]              n_status;
    logic                    n_acc;

    assign is_store  = (r_in.mode == MODE_STORE);
    assign is_mark   = (r_in.mode == MODE_MARK);
    assign full      = (r_fill == CNT_W'(MAX_ENTRIES));
    assign match_now = (r_q_id == r_in.msg_id) && !r_found;
    assign eff_done  = r_q_done || (is_mark && match_now);
    assign do_append = is_store && !full && !r_found;
    assign do_mark   = is_mark && r_found;
    assign wr_idx    = do_append ? r_fill[IDX_W-1:0] : r_m_idx;

    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.rd_last   = (CNT_W'(r_rd_idx) == (r_fill - CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_q_id   <= mem_id[r_rd_idx];
            r_q_pay  <= mem_pay[r_rd_idx];
            r_q_done <= mem_done[r_rd_idx];
        end
        if (i_cmd.commit && (do_append || do_mark)) begin
            mem_done[wr_idx] <= do_append ? r_in.msg_delivered : 1'b1;
        end
        if (i_cmd.commit && do_append) begin
            mem_id[wr_idx]  <= r_in.msg_id;
            mem_pay[wr_idx] <= r_in.msg_payload[PAYLOAD_BITS-1:0];
        end
    end

    always_comb begin
        n_pv     = r_pv;
        n_pid    = r_pid;
        n_ppay   = r_ppay;
        n_pend   = r_pend;
        n_fill   = r_fill;
        n_status = ST_PEEK;
        n_acc    = r_pv;
        if (do_append) begin
            n_fill = r_fill + CNT_W'(1);
            if (!r_in.msg_delivered) begin
                n_pend = r_pend + CNT_W'(1);
                if (!r_pv) begin
                    n_pv   = 1'b1;
                    n_pid  = r_in.msg_id;
                    n_ppay = r_in.msg_payload[PAYLOAD_BITS-1:0];
                end
            end
        end
        if (is_store) begin
            priority if (full) begin
                n_status = ST_FULL;
                n_acc    = 1'b0;
            end else if (r_found) begin
                n_status = ST_DUPLICATE;
                n_acc    = 1'b1;
            end else begin
                n_status = ST_STORED;
                n_acc    = 1'b1;
            end
        end else if (is_mark) begin
            n_status = r_found ? ST_MARKED : ST_NOT_FOUND;
            n_acc    = r_found;
        end else begin
            n_acc    = n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.read) begin
            r_ev_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_res.status          <= n_status;
            r_res.accepted        <= n_acc;
            r_res.pending_valid   <= n_pv;
            r_res.pending_id      <= n_pid;
            r_res.pending_payload <= 64'(n_ppay);
            r_res.pending_count   <= 5'(n_pend);
            r_res.stored_count    <= 5'(n_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_rd_idx  <= '0;
            r_dv      <= 1'b0;
            r_found   <= 1'b0;
            r_m_idx   <= '0;
            r_pv      <= 1'b0;
            r_pid     <= '0;
            r_ppay    <= '0;
            r_pend    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_dv      <= i_cmd.read;
            r_res_vld <= i_cmd.commit;
            if (i_cmd.load) begin
                r_rd_idx <= '0;
                r_found  <= 1'b0;
                r_m_idx  <= '0;
                r_pv     <= 1'b0;
                r_pid    <= '0;
                r_ppay   <= '0;
                r_pend   <= '0;
            end else if (i_cmd.read) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (r_dv) begin
                if (match_now) begin
                    r_found <= 1'b1;
                    r_m_idx <= r_ev_idx;
                end
                if (!eff_done) begin
                    r_pend <= r_pend + CNT_W'(1);
                    if (!r_pv) begin
                        r_pv   <= 1'b1;
                        r_pid  <= r_q_id;
                        r_ppay <= r_q_pay;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_fill <= n_fill;
            end
        end
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

endmodule

FILE: sim/dedup_message_store_table_core_test.sv
`timescale 1ns / 1ps

module dedup_message_store_table_core_test;
    import dmst_pkg::*;

    localparam logic [1:0]  MODE_SPARE = 2'd3;
    localparam logic [63:0] PAY_MASK   = {64{1'b1}} >> (64 - PAYLOAD_BITS);
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 50;
    localparam int          RANDOM_CMDS = 750;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    t_out o_res;
    logic o_res_vld;

    dedup_message_store_table_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_res    (o_res),
        .o_res_vld(o_res_vld)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow table
    logic [31:0] tbl_id   [MAX_ENTRIES];
    logic [63:0] tbl_pay  [MAX_ENTRIES];
    logic        tbl_done [MAX_ENTRIES];
    int          tbl_fill = 0;

    t_in  cmd_q[$];
    t_out answer_q[$];
    int   cyc = 0;
    int   sent_n = 0;
    int   checked_n = 0;
    int   errors = 0;
    int   status_seen[8];

    function automatic t_out table_apply(input t_in c);
        t_out r;
        int   hit;
        int   pend;
        r = '0;
        hit = tbl_fill;
        for (int i = 0; i < tbl_fill; i++) begin
            if (hit == tbl_fill && tbl_id[i] == c.msg_id) begin
                hit = i;
            end
        end
        case (c.mode)
            MODE_STORE: begin
                if (tbl_fill >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else if (hit < tbl_fill) begin
                    r.status = ST_DUPLICATE;
                    r.accepted = 1'b1;
                end else begin
                    tbl_id[tbl_fill] = c.msg_id;
                    tbl_pay[tbl_fill] = c.msg_payload & PAY_MASK;
                    tbl_done[tbl_fill] = c.msg_delivered;
                    tbl_fill++;
                    r.status = ST_STORED;
                    r.accepted = 1'b1;
                end
            end
            MODE_MARK: begin
                if (hit < tbl_fill) begin
                    tbl_done[hit] = 1'b1;
                    r.status = ST_MARKED;
                    r.accepted = 1'b1;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                r.status = ST_PEEK;
            end
        endcase
        pend = 0;
        for (int i = 0; i < tbl_fill; i++) begin
            if (!tbl_done[i]) begin
                if (!r.pending_valid) begin
                    r.pending_valid = 1'b1;
                    r.pending_id = tbl_id[i];
                    r.pending_payload = tbl_pay[i];
                end
                pend++;
            end
        end
        if (r.status == ST_PEEK) begin
            r.accepted = r.pending_valid;
        end
        r.pending_count = pend[4:0];
        r.stored_count = tbl_fill[4:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    function automatic t_in mk_cmd(input logic [1:0] mode, input logic [31:0] id,
                                   input logic dlv, input logic [63:0] pay);
        t_in c;
        c.mode = mode;
        c.msg_id = id;
        c.msg_delivered = dlv;
        c.msg_payload = pay;
        return c;
    endfunction

    // reset and watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == 5) begin
            i_rst_n <= 1'b1;
        end
        if (cyc == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // driver: no gaps during a burst window in the middle of the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                answer_q.push_back(table_apply(i_item));
                sent_n++;
            end
            if (!start || !busy) begin
                if (cmd_q.size() > 0 &&
                    ((sent_n >= 300 && sent_n < 450) || $urandom_range(0, 99) >= 26)) begin
                    start <= 1'b1;
                    i_item <= cmd_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_res_vld) begin
            if (answer_q.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
            end else begin
                w = answer_q.pop_front();
                check_field("status", 64'(w.status), 64'(o_res.status));
                check_field("accepted", 64'(w.accepted), 64'(o_res.accepted));
                check_field("pending_valid", 64'(w.pending_valid), 64'(o_res.pending_valid));
                check_field("pending_id", 64'(w.pending_id), 64'(o_res.pending_id));
                check_field("pending_payload", w.pending_payload, o_res.pending_payload);
                check_field("pending_count", 64'(w.pending_count), 64'(o_res.pending_count));
                check_field("stored_count", 64'(w.stored_count), 64'(o_res.stored_count));
                status_seen[w.status]++;
                checked_n++;
            end
        end
    end

    initial begin
        logic [31:0] gen_ids[$];
        logic [31:0] id;
        logic [1:0]  mode;
        int          r;
        bit          known;

        // empty table, extremes, duplicate keeps entry, store already delivered
        cmd_q.push_back(mk_cmd(MODE_PEEK, 32'h0, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_MARK, 32'h0, 1'b1, {64{1'b1}}));
        cmd_q.push_back(mk_cmd(MODE_SPARE, {32{1'b1}}, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_STORE, 32'h0, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_STORE, {32{1'b1}}, 1'b0, {64{1'b1}}));
        cmd_q.push_back(mk_cmd(MODE_STORE, 32'h0, 1'b1, {64{1'b1}}));
        cmd_q.push_back(mk_cmd(MODE_STORE, 32'h5a5a5a5a, 1'b1, 64'h5a5a5a5a5a5a5a5a));
        cmd_q.push_back(mk_cmd(MODE_PEEK, 32'h0, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_MARK, 32'h0, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_MARK, 32'h0, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_MARK, 32'h12345678, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_MARK, 32'h5a5a5a5a, 1'b0, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_STORE, 32'ha5a5a5a5, 1'b0, 64'h5555aaaa5555aaaa));
        cmd_q.push_back(mk_cmd(MODE_SPARE, 32'h0, 1'b1, {64{1'b1}}));
        cmd_q.push_back(mk_cmd(MODE_MARK, {32{1'b1}}, 1'b1, 64'h0));
        cmd_q.push_back(mk_cmd(MODE_PEEK, 32'h0, 1'b0, 64'h0));
        gen_ids = '{32'h0, 32'hffffffff, 32'h5a5a5a5a, 32'ha5a5a5a5};

        // table fills slowly, then stays full for the rest of the run
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            r = $urandom_range(0, 99);
            mode = (r < 40) ? MODE_STORE : (r < 65) ? MODE_MARK :
                   (r < 90) ? MODE_PEEK : MODE_SPARE;
            if ((mode == MODE_STORE && $urandom_range(0, 3) != 0) ||
                (mode == MODE_MARK && $urandom_range(0, 5) == 0)) begin
                id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
            end else begin
                id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom;
            end
            if (mode == MODE_STORE) begin
                known = 1'b0;
                foreach (gen_ids[k]) begin
                    if (gen_ids[k] == id) begin
                        known = 1'b1;
                    end
                end
                if (!known && gen_ids.size() < MAX_ENTRIES) begin
                    gen_ids.push_back(id);
                end
            end
            cmd_q.push_back(mk_cmd(mode, id, $urandom_range(0, 3) == 0,
                                   {$urandom, $urandom}));
        end

        while (cmd_q.size() != 0 || start || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d commands sent, %0d results checked, %0d mismatches",
                 sent_n, checked_n, errors);
        $display("tb: stored %0d, duplicate %0d, full %0d, marked %0d, not found %0d, peek %0d",
                 status_seen[ST_STORED], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
                 status_seen[ST_MARKED], status_seen[ST_NOT_FOUND], status_seen[ST_PEEK]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
